// File: src/opf_pkg.sv
`timescale 1ns / 1ps

package opf_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SIDE_DEF  = 256;
  localparam int RAD_BITS_DEF  = 24;

  // Fixed field widths of the ports.
  localparam int DIR_W         = 16;
  localparam int IDX_W         = 16;
  localparam int FIELD_RAD_W   = 24;
  localparam int CFG_W         = 9;

  localparam int SIDE_RESET    = 256;
  localparam int CMD_DEPTH     = 4;

  // Q.16 one, minimum surviving weight in Q.32, and one degree in Q1.15.
  localparam int ONE_Q16       = 65536;
  localparam int WEIGHT_FLOOR  = 4295;
  localparam int COS_ONE_DEG   = 32763;
  localparam int SIN_ONE_DEG   = 572;

  // Tap weights are Q.32 and the full sum reaches 2^32.
  localparam int WGT_W         = 33;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_FETCH  = 1'b1;

  typedef enum logic {
    CMD_LOAD,
    CMD_FETCH
  } cmd_kind_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_COORD,
    ST_CLAMP,
    ST_ADDR,
    ST_READ,
    ST_ACC,
    ST_CHECK,
    ST_SQ,
    ST_SQSUM,
    ST_ROOT,
    ST_AIM,
    ST_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    DIV_PX,
    DIV_PZ,
    DIV_NX,
    DIV_NZ,
    DIV_CR,
    DIV_CG,
    DIV_CB
  } div_sel_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } queue_ctl_t;

endpackage

// File: src/opf_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QW bits, so the top of the dividend starts as the
// partial remainder.
module opf_divider #(
  parameter int DW = 57,
  parameter int VW = 33,
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [VW-1:0] rem_r;
  logic [QW-1:0] low_r;
  logic [QW-1:0] quot_r;
  logic [VW-1:0] dvs_r;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem_r, low_r[QW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= VW'(dividend >> QW);
      low_r <= dividend[QW-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r  <= fits ? VW'(trial - {1'b0, dvs_r}) : VW'(trial);
      low_r  <= {low_r[QW-2:0], 1'b0};
      quot_r <= {quot_r[QW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

// File: src/opf_front.sv
`timescale 1ns / 1ps

// Takes items, sorts loads from fetches, drops loads that fall outside the
// store, and holds the rest in a short command queue for the back end.
module opf_front #(
  parameter int MAX_SIDE      = opf_pkg::MAX_SIDE_DEF,
  parameter int RADIANCE_BITS = opf_pkg::RAD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic                                  in_mode,
  input  logic signed [opf_pkg::DIR_W-1:0]      in_dir_x,
  input  logic signed [opf_pkg::DIR_W-1:0]      in_dir_y,
  input  logic signed [opf_pkg::DIR_W-1:0]      in_dir_z,
  input  logic [opf_pkg::IDX_W-1:0]             in_texel_index,
  input  logic [opf_pkg::FIELD_RAD_W-1:0]       in_texel_red,
  input  logic [opf_pkg::FIELD_RAD_W-1:0]       in_texel_green,
  input  logic [opf_pkg::FIELD_RAD_W-1:0]       in_texel_blue,
  input  logic                                  in_texel_above,
  output opf_pkg::queue_ctl_t                   q_status,
  input  logic                                  q_pop,
  output opf_pkg::cmd_kind_t                    q_kind,
  output opf_pkg::dir_t                         q_dir,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  q_index,
  output logic [RADIANCE_BITS-1:0]              q_red,
  output logic [RADIANCE_BITS-1:0]              q_green,
  output logic [RADIANCE_BITS-1:0]              q_blue,
  output logic                                  q_above
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = 1 + 3 * opf_pkg::DIR_W + AW + 3 * RADIANCE_BITS + 1;
  localparam int PW    = $clog2(opf_pkg::CMD_DEPTH);
  localparam int NW    = $clog2(opf_pkg::CMD_DEPTH + 1);

  logic [EW-1:0] queue_mem [opf_pkg::CMD_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [NW-1:0] count_r;
  logic          accept;
  logic          keep;
  logic          take;
  opf_pkg::cmd_kind_t kind;
  opf_pkg::dir_t      dir_in;

  assign in_full = count_r == NW'(opf_pkg::CMD_DEPTH);
  assign accept  = in_push && !in_full;
  assign kind    = (in_mode == opf_pkg::MODE_FETCH) ? opf_pkg::CMD_FETCH : opf_pkg::CMD_LOAD;
  // A load aimed past the end of the store is taken and then forgotten.
  assign keep    = (kind == opf_pkg::CMD_FETCH) || (32'(in_texel_index) < 32'(DEPTH));
  assign take    = q_pop && (count_r != '0);
  assign dir_in  = '{x: in_dir_x, y: in_dir_y, z: in_dir_z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (accept && keep) begin
        wr_ptr_r <= (wr_ptr_r == PW'(opf_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (take) begin
        rd_ptr_r <= (rd_ptr_r == PW'(opf_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_r + NW'(accept && keep) - NW'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      queue_mem[wr_ptr_r] <= {kind, dir_in, AW'(in_texel_index),
                              RADIANCE_BITS'(in_texel_red),
                              RADIANCE_BITS'(in_texel_green),
                              RADIANCE_BITS'(in_texel_blue), in_texel_above};
    end
  end

  assign {q_kind, q_dir, q_index, q_red, q_green, q_blue, q_above} = queue_mem[rd_ptr_r];
  assign q_status.valid = count_r != '0;
  assign q_status.pop   = take;

endmodule

// File: src/opf_back.sv
`timescale 1ns / 1ps

// Executes commands: writes texels, or runs the octahedral fetch with the
// gated bilinear taps, the one-degree re-aim and the final result register.
module opf_back #(
  parameter int MAX_SIDE      = opf_pkg::MAX_SIDE_DEF,
  parameter int RADIANCE_BITS = opf_pkg::RAD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [$clog2(MAX_SIDE+1)-1:0]         side,
  input  opf_pkg::queue_ctl_t                   q_status,
  output logic                                  q_pop,
  input  opf_pkg::cmd_kind_t                    q_kind,
  input  opf_pkg::dir_t                         q_dir,
  input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  q_index,
  input  logic [RADIANCE_BITS-1:0]              q_red,
  input  logic [RADIANCE_BITS-1:0]              q_green,
  input  logic [RADIANCE_BITS-1:0]              q_blue,
  input  logic                                  q_above,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic [opf_pkg::FIELD_RAD_W-1:0]       out_red,
  output logic [opf_pkg::FIELD_RAD_W-1:0]       out_green,
  output logic [opf_pkg::FIELD_RAD_W-1:0]       out_blue,
  output logic                                  out_reaimed,
  output logic                                  out_no_match
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int XW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int RB    = RADIANCE_BITS;
  localparam int TW    = 3 * RB + 1;
  localparam int PW    = 18 + SW;
  localparam int WW    = opf_pkg::WGT_W;
  localparam int SUMW  = RB + 32;
  localparam int DW    = RB + 33;
  localparam int QW    = (RB > 17) ? RB : 17;
  localparam int OW    = opf_pkg::FIELD_RAD_W;

  opf_pkg::back_state_t state_r, state_nxt;
  opf_pkg::div_sel_t    sel_r;

  logic [TW-1:0]   tex_mem [DEPTH];
  logic [TW-1:0]   rd_word_r;

  opf_pkg::dir_t   cur_dir_r;
  logic            reaim_r;
  logic [16:0]     den_r;
  logic [16:0]     pxm_r, pzm_r;
  logic [PW-1:0]   prod_x_r, prod_y_r;
  logic [XW-1:0]   x0_r, x1_r, y0_r, y1_r;
  logic [15:0]     fx_r, fy_r;
  logic [1:0]      tap_r;
  logic [AW-1:0]   addr_r;
  logic [WW-1:0]   w_r, ws_r;
  logic [SUMW-1:0] sum_red_r, sum_green_r, sum_blue_r;
  logic [OW-1:0]   col_red_r, col_green_r, col_blue_r;
  logic            miss_r;
  logic [31:0]     sqx_r, sqz_r;
  logic [32:0]     root_v_r, root_r, root_bit_r;

  logic            out_valid_r;
  logic [OW-1:0]   res_red_r, res_green_r, res_blue_r;
  logic            res_reaimed_r, res_no_match_r;

  logic            mem_we;
  logic            res_load;
  logic            div_start;
  logic            div_done;
  logic [DW-1:0]   div_dividend;
  logic [WW-1:0]   div_divisor;
  logic [QW-1:0]   div_q;

  // Magnitudes and signs of the current direction.
  logic [15:0]     ax, ay, az;
  logic            x_neg, y_neg, z_neg;

  assign x_neg = cur_dir_r.x[15];
  assign y_neg = cur_dir_r.y[15];
  assign z_neg = cur_dir_r.z[15];
  assign ax = x_neg ? (~cur_dir_r.x + 16'd1) : cur_dir_r.x;
  assign ay = y_neg ? (~cur_dir_r.y + 16'd1) : cur_dir_r.y;
  assign az = z_neg ? (~cur_dir_r.z + 16'd1) : cur_dir_r.z;

  // Octahedral fold: the lower hemisphere swaps the magnitudes into the corners.
  logic [16:0]     mag_x, mag_z;
  logic [17:0]     u_x, u_z;

  assign mag_x = y_neg ? 17'(opf_pkg::ONE_Q16) - pzm_r : pxm_r;
  assign mag_z = y_neg ? 17'(opf_pkg::ONE_Q16) - pxm_r : pzm_r;
  assign u_x   = x_neg ? 18'(opf_pkg::ONE_Q16) - 18'(mag_x) : 18'(opf_pkg::ONE_Q16) + 18'(mag_x);
  assign u_z   = z_neg ? 18'(opf_pkg::ONE_Q16) - 18'(mag_z) : 18'(opf_pkg::ONE_Q16) + 18'(mag_z);

  // Texel coordinate in Q.17, clamped to the map.
  logic [SW-1:0]   side_m1;
  logic [PW-1:0]   t_hi, tx_lo, ty_lo, tx_c, ty_c;
  logic [XW-1:0]   x0_c, y0_c;

  assign side_m1 = side - SW'(1);
  assign t_hi    = PW'(side_m1) << 17;
  assign tx_lo   = (prod_x_r < PW'(opf_pkg::ONE_Q16)) ? '0 : prod_x_r - PW'(opf_pkg::ONE_Q16);
  assign ty_lo   = (prod_y_r < PW'(opf_pkg::ONE_Q16)) ? '0 : prod_y_r - PW'(opf_pkg::ONE_Q16);
  assign tx_c    = (tx_lo > t_hi) ? t_hi : tx_lo;
  assign ty_c    = (ty_lo > t_hi) ? t_hi : ty_lo;
  assign x0_c    = XW'(tx_c >> 17);
  assign y0_c    = XW'(ty_c >> 17);

  // Current tap and its weight.
  logic [XW-1:0]   cx, cy;
  logic [16:0]     wx, wy;

  assign cx = tap_r[0] ? x1_r : x0_r;
  assign cy = tap_r[1] ? y1_r : y0_r;
  assign wx = tap_r[0] ? {1'b0, fx_r} : 17'(opf_pkg::ONE_Q16) - {1'b0, fx_r};
  assign wy = tap_r[1] ? {1'b0, fy_r} : 17'(opf_pkg::ONE_Q16) - {1'b0, fy_r};

  logic [RB-1:0]   rd_red, rd_green, rd_blue;
  logic            rd_above;
  logic            tap_hit;

  assign {rd_above, rd_red, rd_green, rd_blue} = rd_word_r;
  assign tap_hit = rd_above == !y_neg;

  logic            weight_low;
  logic [32:0]     root_try;
  logic [15:0]     quot16;
  logic [15:0]     sin_pos;

  assign weight_low = ws_r < WW'(opf_pkg::WEIGHT_FLOOR);
  assign root_try   = root_r + root_bit_r;
  assign quot16     = 16'(div_q);
  assign sin_pos    = 16'(opf_pkg::SIN_ONE_DEG);

  opf_divider #(
    .DW (DW),
    .VW (WW),
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      opf_pkg::ST_IDLE: begin
        if (q_status.valid && q_kind == opf_pkg::CMD_FETCH) begin
          state_nxt = opf_pkg::ST_DEN;
        end
      end
      opf_pkg::ST_DEN: begin
        state_nxt = (ax == '0 && ay == '0 && az == '0) ? opf_pkg::ST_COORD
                                                        : opf_pkg::ST_DIV_GO;
      end
      opf_pkg::ST_DIV_GO:   state_nxt = opf_pkg::ST_DIV_WAIT;
      opf_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          unique case (sel_r)
            opf_pkg::DIV_PZ: state_nxt = opf_pkg::ST_COORD;
            opf_pkg::DIV_NZ: state_nxt = opf_pkg::ST_DEN;
            opf_pkg::DIV_CB: state_nxt = opf_pkg::ST_OUT;
            default:         state_nxt = opf_pkg::ST_DIV_GO;
          endcase
        end
      end
      opf_pkg::ST_COORD: state_nxt = opf_pkg::ST_CLAMP;
      opf_pkg::ST_CLAMP: state_nxt = opf_pkg::ST_ADDR;
      opf_pkg::ST_ADDR:  state_nxt = opf_pkg::ST_READ;
      opf_pkg::ST_READ:  state_nxt = opf_pkg::ST_ACC;
      opf_pkg::ST_ACC:   state_nxt = (tap_r == 2'd3) ? opf_pkg::ST_CHECK : opf_pkg::ST_ADDR;
      opf_pkg::ST_CHECK: begin
        priority if (!weight_low) state_nxt = opf_pkg::ST_DIV_GO;
        else if (!reaim_r)        state_nxt = opf_pkg::ST_SQ;
        else                      state_nxt = opf_pkg::ST_OUT;
      end
      opf_pkg::ST_SQ:    state_nxt = opf_pkg::ST_SQSUM;
      opf_pkg::ST_SQSUM: state_nxt = opf_pkg::ST_ROOT;
      opf_pkg::ST_ROOT:  state_nxt = (root_bit_r == 33'd1) ? opf_pkg::ST_AIM : opf_pkg::ST_ROOT;
      opf_pkg::ST_AIM:   state_nxt = (root_r == '0) ? opf_pkg::ST_DEN : opf_pkg::ST_DIV_GO;
      opf_pkg::ST_OUT: begin
        if (!out_valid_r || out_pop) state_nxt = opf_pkg::ST_IDLE;
      end
      default: state_nxt = opf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = (state_r == opf_pkg::ST_IDLE) && q_status.valid;
    mem_we       = q_pop && (q_kind == opf_pkg::CMD_LOAD);
    res_load     = (state_r == opf_pkg::ST_OUT) && (!out_valid_r || out_pop);
    div_start    = state_r == opf_pkg::ST_DIV_GO;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (sel_r)
      opf_pkg::DIV_PX: begin
        div_dividend = DW'({ax, 16'd0});
        div_divisor  = WW'(den_r);
      end
      opf_pkg::DIV_PZ: begin
        div_dividend = DW'({az, 16'd0});
        div_divisor  = WW'(den_r);
      end
      opf_pkg::DIV_NX: begin
        div_dividend = DW'(32'(ax) * 32'(opf_pkg::COS_ONE_DEG));
        div_divisor  = WW'(root_r);
      end
      opf_pkg::DIV_NZ: begin
        div_dividend = DW'(32'(az) * 32'(opf_pkg::COS_ONE_DEG));
        div_divisor  = WW'(root_r);
      end
      opf_pkg::DIV_CR: begin
        div_dividend = DW'(sum_red_r) + DW'(ws_r >> 1);
        div_divisor  = ws_r;
      end
      opf_pkg::DIV_CG: begin
        div_dividend = DW'(sum_green_r) + DW'(ws_r >> 1);
        div_divisor  = ws_r;
      end
      opf_pkg::DIV_CB: begin
        div_dividend = DW'(sum_blue_r) + DW'(ws_r >> 1);
        div_divisor  = ws_r;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= opf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tex_mem[q_index] <= {q_above, q_red, q_green, q_blue};
    end
    if (state_r == opf_pkg::ST_READ) begin
      rd_word_r <= tex_mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      opf_pkg::ST_IDLE: begin
        cur_dir_r <= q_dir;
        reaim_r   <= 1'b0;
      end
      opf_pkg::ST_DEN: begin
        den_r <= 17'(ax) + 17'(ay) + 17'(az);
        pxm_r <= '0;
        pzm_r <= '0;
        sel_r <= opf_pkg::DIV_PX;
      end
      opf_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          unique case (sel_r)
            opf_pkg::DIV_PX: begin
              pxm_r <= 17'(div_q);
              sel_r <= opf_pkg::DIV_PZ;
            end
            opf_pkg::DIV_PZ: pzm_r <= 17'(div_q);
            opf_pkg::DIV_NX: begin
              pxm_r <= 17'(div_q);
              sel_r <= opf_pkg::DIV_NZ;
            end
            opf_pkg::DIV_NZ: begin
              // The re-aimed x magnitude was parked in pxm_r.
              cur_dir_r.x <= x_neg ? (~16'(pxm_r) + 16'd1) : 16'(pxm_r);
              cur_dir_r.y <= y_neg ? (~sin_pos + 16'd1) : sin_pos;
              cur_dir_r.z <= z_neg ? (~quot16 + 16'd1) : quot16;
            end
            opf_pkg::DIV_CR: begin
              col_red_r <= OW'(div_q);
              sel_r     <= opf_pkg::DIV_CG;
            end
            opf_pkg::DIV_CG: begin
              col_green_r <= OW'(div_q);
              sel_r       <= opf_pkg::DIV_CB;
            end
            opf_pkg::DIV_CB: col_blue_r <= OW'(div_q);
            default: sel_r <= opf_pkg::DIV_PX;
          endcase
        end
      end
      opf_pkg::ST_COORD: begin
        prod_x_r <= PW'(u_x) * PW'(side);
        prod_y_r <= PW'(u_z) * PW'(side);
      end
      opf_pkg::ST_CLAMP: begin
        x0_r <= x0_c;
        y0_r <= y0_c;
        x1_r <= ((SW'(x0_c) + SW'(1)) < side) ? x0_c + XW'(1) : XW'(side_m1);
        y1_r <= ((SW'(y0_c) + SW'(1)) < side) ? y0_c + XW'(1) : XW'(side_m1);
        fx_r <= tx_c[16:1];
        fy_r <= ty_c[16:1];
        tap_r       <= '0;
        ws_r        <= '0;
        sum_red_r   <= '0;
        sum_green_r <= '0;
        sum_blue_r  <= '0;
      end
      opf_pkg::ST_ADDR: begin
        addr_r <= AW'(cy) * AW'(side) + AW'(cx);
        w_r    <= WW'(34'(wx) * 34'(wy));
      end
      opf_pkg::ST_ACC: begin
        if (tap_hit) begin
          sum_red_r   <= sum_red_r + SUMW'(rd_red * w_r);
          sum_green_r <= sum_green_r + SUMW'(rd_green * w_r);
          sum_blue_r  <= sum_blue_r + SUMW'(rd_blue * w_r);
          ws_r        <= ws_r + w_r;
        end
        tap_r <= tap_r + 2'd1;
      end
      opf_pkg::ST_CHECK: begin
        miss_r <= weight_low && reaim_r;
        sel_r  <= opf_pkg::DIV_CR;
        if (weight_low) begin
          reaim_r <= 1'b1;
        end
        if (weight_low && reaim_r) begin
          col_red_r   <= '0;
          col_green_r <= '0;
          col_blue_r  <= '0;
        end
      end
      opf_pkg::ST_SQ: begin
        sqx_r <= 32'(ax) * 32'(ax);
        sqz_r <= 32'(az) * 32'(az);
      end
      opf_pkg::ST_SQSUM: begin
        root_v_r   <= 33'(sqx_r) + 33'(sqz_r);
        root_r     <= '0;
        root_bit_r <= 33'd1 << 30;
      end
      opf_pkg::ST_ROOT: begin
        if (root_v_r >= root_try) begin
          root_v_r <= root_v_r - root_try;
          root_r   <= (root_r >> 1) + root_bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        root_bit_r <= root_bit_r >> 2;
      end
      opf_pkg::ST_AIM: begin
        sel_r <= opf_pkg::DIV_NX;
        if (root_r == '0) begin
          // Straight up or down: keep only the vertical component.
          cur_dir_r.x <= '0;
          cur_dir_r.y <= y_neg ? (~sin_pos + 16'd1) : sin_pos;
          cur_dir_r.z <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_red_r      <= col_red_r;
      res_green_r    <= col_green_r;
      res_blue_r     <= col_blue_r;
      res_reaimed_r  <= reaim_r;
      res_no_match_r <= miss_r;
    end
  end

  assign out_empty    = !out_valid_r;
  assign out_red      = res_red_r;
  assign out_green    = res_green_r;
  assign out_blue     = res_blue_r;
  assign out_reaimed  = res_reaimed_r;
  assign out_no_match = res_no_match_r;

endmodule

// File: src/octahedral_probe_fetch_top.sv
`timescale 1ns / 1ps

// Channel   Handshake              Carries
// in_       in_push / in_full      load or fetch item (mode, direction, texel)
// out_      out_pop / out_empty    fetched radiance, reaimed, no_match
// cfg_      cfg_valid / cfg_ready  side_in_use, always ready
//
// A load is written to the texel store as it leaves the queue. A fetch runs
// its divisions one after another on the shared serial divider, one quotient
// bit per cycle. A re-aimed fetch runs the bilinear pass twice, with a
// bit-serial square root before the second pass. No clearing pass:
// the texel store is valid as written. A four-entry queue keeps accepting
// items while the result register waits for out_pop.
module octahedral_probe_fetch_top #(
  parameter int MAX_SIDE      = opf_pkg::MAX_SIDE_DEF,
  parameter int RADIANCE_BITS = opf_pkg::RAD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_mode,
  input  logic signed [opf_pkg::DIR_W-1:0]  in_dir_x,
  input  logic signed [opf_pkg::DIR_W-1:0]  in_dir_y,
  input  logic signed [opf_pkg::DIR_W-1:0]  in_dir_z,
  input  logic [opf_pkg::IDX_W-1:0]         in_texel_index,
  input  logic [opf_pkg::FIELD_RAD_W-1:0]   in_texel_red,
  input  logic [opf_pkg::FIELD_RAD_W-1:0]   in_texel_green,
  input  logic [opf_pkg::FIELD_RAD_W-1:0]   in_texel_blue,
  input  logic                              in_texel_above,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [opf_pkg::FIELD_RAD_W-1:0]   out_red,
  output logic [opf_pkg::FIELD_RAD_W-1:0]   out_green,
  output logic [opf_pkg::FIELD_RAD_W-1:0]   out_blue,
  output logic                              out_reaimed,
  output logic                              out_no_match,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [opf_pkg::CFG_W-1:0]         cfg_side_in_use
);

  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);

  logic [opf_pkg::CFG_W-1:0] side_cfg_r;
  logic [SW-1:0]             side_eff;

  opf_pkg::queue_ctl_t       q_status;
  logic                      q_pop;
  opf_pkg::cmd_kind_t        q_kind;
  opf_pkg::dir_t             q_dir;
  logic [AW-1:0]             q_index;
  logic [RADIANCE_BITS-1:0]  q_red, q_green, q_blue;
  logic                      q_above;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_cfg_r <= opf_pkg::CFG_W'(opf_pkg::SIDE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      side_cfg_r <= cfg_side_in_use;
    end
  end

  // The map edge saturates to the range the store can hold.
  always_comb begin
    priority if (32'(side_cfg_r) < 32'd2) side_eff = SW'(2);
    else if (32'(side_cfg_r) > 32'(MAX_SIDE)) side_eff = SW'(MAX_SIDE);
    else side_eff = SW'(side_cfg_r);
  end

  opf_front #(
    .MAX_SIDE      (MAX_SIDE),
    .RADIANCE_BITS (RADIANCE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_dir_z       (in_dir_z),
    .in_texel_index (in_texel_index),
    .in_texel_red   (in_texel_red),
    .in_texel_green (in_texel_green),
    .in_texel_blue  (in_texel_blue),
    .in_texel_above (in_texel_above),
    .q_status       (q_status),
    .q_pop          (q_pop),
    .q_kind         (q_kind),
    .q_dir          (q_dir),
    .q_index        (q_index),
    .q_red          (q_red),
    .q_green        (q_green),
    .q_blue         (q_blue),
    .q_above        (q_above)
  );

  opf_back #(
    .MAX_SIDE      (MAX_SIDE),
    .RADIANCE_BITS (RADIANCE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .side         (side_eff),
    .q_status     (q_status),
    .q_pop        (q_pop),
    .q_kind       (q_kind),
    .q_dir        (q_dir),
    .q_index      (q_index),
    .q_red        (q_red),
    .q_green      (q_green),
    .q_blue       (q_blue),
    .q_above      (q_above),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_reaimed  (out_reaimed),
    .out_no_match (out_no_match)
  );

endmodule

// File: verif/octahedral_probe_fetch_top_test.sv
`timescale 1ns / 1ps

module octahedral_probe_fetch_top_test;
  import opf_pkg::*;

  typedef struct {
    logic [FIELD_RAD_W-1:0] red;
    logic [FIELD_RAD_W-1:0] green;
    logic [FIELD_RAD_W-1:0] blue;
    logic                   reaimed;
    logic                   no_match;
  } radiance_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_mode = MODE_LOAD;
  logic signed [DIR_W-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic [IDX_W-1:0] in_texel_index = '0;
  logic [FIELD_RAD_W-1:0] in_texel_red = '0, in_texel_green = '0, in_texel_blue = '0;
  logic in_texel_above = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [FIELD_RAD_W-1:0] out_red, out_green, out_blue;
  logic out_reaimed, out_no_match;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_side_in_use = '0;

  octahedral_probe_fetch_top dut (.*);

  always #6 clk = ~clk;

  // Mirror of the texel store and the side register.
  logic [FIELD_RAD_W-1:0] red_mem [65536];
  logic [FIELD_RAD_W-1:0] green_mem [65536];
  logic [FIELD_RAD_W-1:0] blue_mem [65536];
  bit above_mem [65536];
  bit written [65536];
  int side_reg = SIDE_RESET;

  radiance_t pending_radiance[$];
  int errors = 0;
  bit quiet = 0;
  int fetches_sent = 0;
  int items_sent = 0;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'd1 << 30;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // One bilinear attempt; notes in miss any texel it would read that was never loaded.
  function automatic bit bilinear_try(longint x, longint y, longint z, int side,
                                      output logic [FIELD_RAD_W-1:0] rgb [3],
                                      inout int miss);
    longint den, px, pz, qx, qz, hi, tx, ty, fx, fy, sr, sg, sb, ws;
    longint w [4];
    int x0, y0, x1, y1, idx;
    int cx [4];
    int cy [4];
    bit upper;
    den = mag(x) + mag(y) + mag(z);
    px = 0;
    pz = 0;
    if (den != 0) begin
      px = (mag(x) * 65536) / den;
      pz = (mag(z) * 65536) / den;
      if (x < 0) px = -px;
      if (z < 0) pz = -pz;
    end
    if (y < 0) begin
      qx = 65536 - mag(pz);
      qz = 65536 - mag(px);
      px = (x < 0) ? -qx : qx;
      pz = (z < 0) ? -qz : qz;
    end
    hi = longint'(side - 1) * 131072;
    tx = (px + 65536) * side - 65536;
    ty = (pz + 65536) * side - 65536;
    if (tx < 0) tx = 0;
    if (tx > hi) tx = hi;
    if (ty < 0) ty = 0;
    if (ty > hi) ty = hi;
    x0 = int'(tx >> 17);
    y0 = int'(ty >> 17);
    fx = (tx & 64'h1FFFF) >> 1;
    fy = (ty & 64'h1FFFF) >> 1;
    x1 = (x0 + 1 < side) ? x0 + 1 : side - 1;
    y1 = (y0 + 1 < side) ? y0 + 1 : side - 1;
    cx = '{x0, x1, x0, x1};
    cy = '{y0, y0, y1, y1};
    w = '{(65536 - fx) * (65536 - fy), fx * (65536 - fy), (65536 - fx) * fy, fx * fy};
    upper = (y >= 0);
    sr = 0; sg = 0; sb = 0; ws = 0;
    for (int k = 0; k < 4; k++) begin
      idx = cy[k] * side + cx[k];
      if (!written[idx]) miss = idx;
      if (above_mem[idx] == upper) begin
        sr += longint'(red_mem[idx]) * w[k];
        sg += longint'(green_mem[idx]) * w[k];
        sb += longint'(blue_mem[idx]) * w[k];
        ws += w[k];
      end
    end
    rgb = '{default: '0};
    if (ws < WEIGHT_FLOOR) return 1'b0;
    rgb[0] = FIELD_RAD_W'((sr + ws / 2) / ws);
    rgb[1] = FIELD_RAD_W'((sg + ws / 2) / ws);
    rgb[2] = FIELD_RAD_W'((sb + ws / 2) / ws);
    return 1'b1;
  endfunction

  function automatic void predict_radiance(longint x, longint y, longint z,
                                           output radiance_t res, output int miss);
    logic [FIELD_RAD_W-1:0] rgb [3];
    longint f, nx, nz, ny;
    int side;
    side = side_reg < 2 ? 2 : (side_reg > MAX_SIDE_DEF ? MAX_SIDE_DEF : side_reg);
    miss = -1;
    res.reaimed = 1'b0;
    res.no_match = 1'b0;
    if (!bilinear_try(x, y, z, side, rgb, miss)) begin
      f = root_floor(x * x + z * z);
      nx = 0;
      nz = 0;
      if (f != 0) begin
        nx = (mag(x) * COS_ONE_DEG) / f;
        nz = (mag(z) * COS_ONE_DEG) / f;
        if (x < 0) nx = -nx;
        if (z < 0) nz = -nz;
      end
      ny = (y >= 0) ? SIN_ONE_DEG : -SIN_ONE_DEG;
      res.reaimed = 1'b1;
      if (!bilinear_try(nx, ny, nz, side, rgb, miss)) begin
        rgb = '{default: '0};
        res.no_match = 1'b1;
      end
    end
    res.red = rgb[0];
    res.green = rgb[1];
    res.blue = rgb[2];
  endfunction

  // Presents one item and returns once it has been accepted.
  task automatic push_item(logic mode, logic signed [DIR_W-1:0] x, y, z,
                           logic [IDX_W-1:0] idx, logic [FIELD_RAD_W-1:0] r, g, b,
                           logic above);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_mode <= mode;
    in_dir_x <= x;
    in_dir_y <= y;
    in_dir_z <= z;
    in_texel_index <= idx;
    in_texel_red <= r;
    in_texel_green <= g;
    in_texel_blue <= b;
    in_texel_above <= above;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_texel(int idx, logic [FIELD_RAD_W-1:0] r, g, b, logic above);
    red_mem[idx] = r;
    green_mem[idx] = g;
    blue_mem[idx] = b;
    above_mem[idx] = above;
    written[idx] = 1'b1;
    push_item(MODE_LOAD, $urandom, $urandom, $urandom, IDX_W'(idx), r, g, b, above);
  endtask

  function automatic logic [FIELD_RAD_W-1:0] rand_radiance();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return FIELD_RAD_W'($urandom);
    endcase
  endfunction

  // Loads any texel the fetch would touch unloaded, then sends the fetch.
  task automatic fetch_dir(logic signed [DIR_W-1:0] x, y, z);
    radiance_t res;
    int miss;
    forever begin
      predict_radiance(x, y, z, res, miss);
      if (miss < 0) break;
      load_texel(miss, rand_radiance(), rand_radiance(), rand_radiance(), $urandom);
    end
    pending_radiance.push_back(res);
    fetches_sent++;
    push_item(MODE_FETCH, x, y, z, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Idle the block, then rewrite the side register.
  task automatic set_side(int side);
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_radiance.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_side_in_use <= CFG_W'(side);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    side_reg = side;
  endtask

  function automatic logic signed [DIR_W-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return DIR_W'($urandom_range(0, 40)) - 16'sd20;
      default: return DIR_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    set_side(2);
    for (int i = 0; i < 4; i++) load_texel(i, '1, '0, FIELD_RAD_W'(i * 1000), 1'b1);
    fetch_dir(0, 0, 0);
    fetch_dir(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    fetch_dir(16'sh8000, 16'sh8000, 16'sh8000);
    fetch_dir(16'sh8000, 16'sh7FFF, 16'sh0000);
    // All flags below the horizon: an upward ray gets re-aimed, then finds nothing.
    for (int i = 0; i < 4; i++) load_texel(i, '0, '1, '1, 1'b0);
    fetch_dir(0, 100, 0);
    fetch_dir(300, 5, -200);
    fetch_dir(0, -100, 0);
    fetch_dir(16'sh8000, -1, 16'sh7FFF);
    load_texel(0, 24'h123456, 24'hABCDEF, 24'h000001, 1'b1);
    fetch_dir(-1000, 2, -1000);
  endtask

  task automatic test_random_phase(int side, int count, bit calm);
    int start;
    set_side(side);
    quiet = calm;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(0, 9) == 0)
        load_texel($urandom_range(0, 65535), rand_radiance(), rand_radiance(),
                   rand_radiance(), $urandom);
      else if ($urandom_range(0, 9) < 2)
        load_texel($urandom_range(0, side_reg * side_reg - 1 < 0 ? 0 :
                   (side_reg > 256 ? 65535 : (side_reg < 2 ? 3 : side_reg * side_reg - 1))),
                   rand_radiance(), rand_radiance(), rand_radiance(), $urandom);
      else
        fetch_dir(rand_comp(), rand_comp(), rand_comp());
    end
    quiet = 0;
  endtask

  // Result side: random stalls, field-by-field comparison.
  int pop_wait = 0;
  always @(posedge clk) begin
    radiance_t want;
    logic next_pop;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_radiance.size() == 0) begin
        $display("%0t: unexpected result red=%h green=%h blue=%h", $time, out_red,
                 out_green, out_blue);
        errors++;
      end else begin
        want = pending_radiance.pop_front();
        if (out_red !== want.red) begin
          $display("%0t: red expected %h actual %h", $time, want.red, out_red);
          errors++;
        end
        if (out_green !== want.green) begin
          $display("%0t: green expected %h actual %h", $time, want.green, out_green);
          errors++;
        end
        if (out_blue !== want.blue) begin
          $display("%0t: blue expected %h actual %h", $time, want.blue, out_blue);
          errors++;
        end
        if (out_reaimed !== want.reaimed) begin
          $display("%0t: reaimed expected %b actual %b", $time, want.reaimed, out_reaimed);
          errors++;
        end
        if (out_no_match !== want.no_match) begin
          $display("%0t: no_match expected %b actual %b", $time, want.no_match,
                   out_no_match);
          errors++;
        end
      end
      pop_wait = quiet ? 0 : $urandom_range(0, 14);
    end
    if (pop_wait > 0) begin
      pop_wait--;
      next_pop = 1'b0;
    end else begin
      next_pop = 1'b1;
    end
    out_pop <= next_pop;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(256, 250, 0);
    test_random_phase(3, 200, 1);
    test_random_phase(0, 120, 0);
    test_random_phase(511, 150, 0);
    test_random_phase(1, 100, 0);
    test_random_phase(17, 200, 0);
    test_random_phase($urandom_range(4, 255), 300, 0);
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_radiance.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0)
      $display("octahedral_probe_fetch_top_test: PASS");
    else
      $display("octahedral_probe_fetch_top_test: FAIL");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("octahedral_probe_fetch_top_test: FAIL");
    $finish;
  end

endmodule

// File: files.f
src/opf_pkg.sv
src/opf_divider.sv
src/opf_front.sv
src/opf_back.sv
src/octahedral_probe_fetch_top.sv
verif/octahedral_probe_fetch_top_test.sv
